>>> rtl/stream_contract_accounting_monitor_unit_defines.svh
// ----------------------------------------------------------------------------
// Stream accounting monitor assertion macros
// Shared property forms for the checker of the stream accounting monitor.
// ----------------------------------------------------------------------------
`ifndef STREAM_CONTRACT_ACCOUNTING_MONITOR_UNIT_DEFINES_SVH
`define STREAM_CONTRACT_ACCOUNTING_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SCAM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCAM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) else $error(msg);

// Next-cycle implication that also covers the reset cycle.
`define SCAM_ASSERT_RESET(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> cons) else $error(msg);

`endif

>>> rtl/scam_pkg.sv
// ----------------------------------------------------------------------------
// Stream accounting monitor package
// Request codes, beat type codes, read select codes and fixed field limits.
// ----------------------------------------------------------------------------
`default_nettype none

package scam_pkg;

  typedef enum logic [1:0] {
    REQ_BEAT  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_EMPTY = 2'd2
  } req_t;

  localparam logic [7:0]  TYPE_PEAK  = 8'h00;
  localparam logic [7:0]  TYPE_CYCLE = 8'h01;
  localparam logic [13:0] CNT14_MAX  = 14'h3fff;
  localparam logic [23:0] HALF_RANGE = 24'h800000;

  localparam logic [4:0] SEL_PEAK       = 5'd0;
  localparam logic [4:0] SEL_CYCLE      = 5'd1;
  localparam logic [4:0] SEL_EVENT_SUM  = 5'd2;
  localparam logic [4:0] SEL_OTHER      = 5'd3;
  localparam logic [4:0] SEL_BAD_LAST   = 5'd4;
  localparam logic [4:0] SEL_MULTI      = 5'd5;
  localparam logic [4:0] SEL_IDX_LOW    = 5'd6;
  localparam logic [4:0] SEL_IDX_HIGH   = 5'd7;
  localparam logic [4:0] SEL_IDX_SEEN   = 5'd8;
  localparam logic [4:0] SEL_POLL_MIN   = 5'd9;
  localparam logic [4:0] SEL_POLL_MAX   = 5'd10;
  localparam logic [4:0] SEL_ZERO_COUNT = 5'd11;

  // Histogram memory layout: zero count, over count, then the buckets.
  localparam int ADDR_ZERO = 0;
  localparam int ADDR_OVER = 1;
  localparam int ADDR_BASE = 2;

endpackage

`default_nettype wire

>>> rtl/scam_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module scam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic      [WIDTH-1:0]         rd_a_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic      [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

>>> rtl/stream_contract_accounting_monitor_unit.sv
// A read result is registered in the s1 stage and then written into the output FIFO, from which it is offered.
// Throughput: one transaction per cycle; the input stalls while waiting read results
// plus one still being formed fill all three output slots. The length histogram lives
// in a RAM updated by read-modify-write in the s1 stage, forwarding the last write.
// Reset: synchronous; clears all counters and the histogram valid flags at once,
// so the block accepts transactions as soon as reset is released.
// ----------------------------------------------------------------------------
// Stream accounting monitor
// Classifies 64-bit beats, keeps word, event, index and poll statistics and a
// packet length histogram, and answers read requests for any counter.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_contract_accounting_monitor_unit #(
  parameter int MAX_PACKET_BEATS = 8191,
  parameter int HIST_BUCKETS     = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [63:0] beat_data,
  input  wire logic        beat_last,
  input  wire logic [24:0] wait_polls,
  input  wire logic [4:0]  stat_select,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] read_value
);

  localparam int DEPTH      = HIST_BUCKETS + 2;
  localparam int AW         = $clog2(DEPTH);
  localparam int FIFO_DEPTH = 3;

  logic        accept;
  logic        is_beat;
  logic        is_read;
  logic        is_empty;
  logic [7:0]  beat_type;
  logic [23:0] beat_idx;
  logic [13:0] beat_evt;
  logic [13:0] bip_inc;
  logic [13:0] cwp_new;
  logic        pkt_end;
  logic [13:0] hist_len;
  logic [AW-1:0] hist_addr;
  logic [23:0] idx_diff;
  logic        idx_advance;
  logic [31:0] polls_ext;
  logic [31:0] scalar_value;
  logic        sel_hist;

  logic [31:0] peak_count;
  logic [31:0] cycle_count;
  logic [31:0] event_sum;
  logic [31:0] other_count;
  logic [31:0] bad_last_count;
  logic [31:0] multi_count;
  logic [23:0] idx_low;
  logic [23:0] idx_high;
  logic        idx_seen;
  logic [31:0] poll_min;
  logic [31:0] poll_max;
  logic [13:0] bip;
  logic [13:0] cwp;

  logic          s1_upd;
  logic [AW-1:0] s1_upd_addr;
  logic          s1_rd;
  logic          s1_rd_hist;
  logic [AW-1:0] s1_rd_addr;
  logic [31:0]   s1_scalar;
  logic          fw_valid;
  logic [AW-1:0] fw_addr;
  logic [31:0]   fw_data;
  logic [DEPTH-1:0] hist_valid;
  logic [31:0]   rd_a_data;
  logic [31:0]   rd_b_data;
  logic [31:0]   upd_base;
  logic [31:0]   wr_data;
  logic [31:0]   hist_value;
  logic [31:0]   s1_result;

  logic [31:0] fifo_mem [FIFO_DEPTH];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign accept    = in_valid && !in_stall;
  assign is_beat   = accept && (req_type == scam_pkg::REQ_BEAT);
  assign is_read   = accept && (req_type == scam_pkg::REQ_READ);
  assign is_empty  = accept && (req_type == scam_pkg::REQ_EMPTY);
  assign beat_type = beat_data[63:56];
  assign beat_idx  = beat_data[55:32];
  assign beat_evt  = beat_data[29:16];
  assign polls_ext = {7'b0, wait_polls};

  assign bip_inc = (bip == scam_pkg::CNT14_MAX) ? bip : bip + 14'd1;
  assign cwp_new = ((beat_type == scam_pkg::TYPE_CYCLE) && (cwp != scam_pkg::CNT14_MAX)) ?
                   cwp + 14'd1 : cwp;
  assign pkt_end  = is_beat && beat_last;
  assign hist_len = is_empty ? 14'd0 : bip_inc;

  assign idx_diff    = beat_idx - idx_high;
  assign idx_advance = (beat_idx > idx_high) && (idx_diff < scam_pkg::HALF_RANGE);

  always_comb begin
    hist_addr = AW'(scam_pkg::ADDR_OVER);
    for (int k = HIST_BUCKETS - 1; k >= 0; k--) begin
      if (int'(hist_len) <= ((k < HIST_BUCKETS - 1) ? (1 << k) : MAX_PACKET_BEATS)) begin
        hist_addr = AW'(k + scam_pkg::ADDR_BASE);
      end
    end
    if (hist_len == 14'd0) begin
      hist_addr = AW'(scam_pkg::ADDR_ZERO);
    end
  end

  always_comb begin
    case (stat_select)
      scam_pkg::SEL_PEAK:      scalar_value = peak_count;
      scam_pkg::SEL_CYCLE:     scalar_value = cycle_count;
      scam_pkg::SEL_EVENT_SUM: scalar_value = event_sum;
      scam_pkg::SEL_OTHER:     scalar_value = other_count;
      scam_pkg::SEL_BAD_LAST:  scalar_value = bad_last_count;
      scam_pkg::SEL_MULTI:     scalar_value = multi_count;
      scam_pkg::SEL_IDX_LOW:   scalar_value = {8'b0, idx_low};
      scam_pkg::SEL_IDX_HIGH:  scalar_value = {8'b0, idx_high};
      scam_pkg::SEL_IDX_SEEN:  scalar_value = {31'b0, idx_seen};
      scam_pkg::SEL_POLL_MIN:  scalar_value = poll_min;
      scam_pkg::SEL_POLL_MAX:  scalar_value = poll_max;
      default:                 scalar_value = 32'd0;
    endcase
  end

  assign sel_hist = (stat_select >= scam_pkg::SEL_ZERO_COUNT) &&
                    ({1'b0, stat_select} < 6'(int'(scam_pkg::SEL_ZERO_COUNT) + DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_count     <= 32'd0;
      cycle_count    <= 32'd0;
      event_sum      <= 32'd0;
      other_count    <= 32'd0;
      bad_last_count <= 32'd0;
      multi_count    <= 32'd0;
      idx_low        <= 24'd0;
      idx_high       <= 24'd0;
      idx_seen       <= 1'b0;
      poll_min       <= '1;
      poll_max       <= 32'd0;
      bip            <= 14'd0;
      cwp            <= 14'd0;
    end else begin
      if (is_beat) begin
        if (beat_type == scam_pkg::TYPE_PEAK) begin
          peak_count <= peak_count + 32'd1;
        end else if (beat_type == scam_pkg::TYPE_CYCLE) begin
          cycle_count <= cycle_count + 32'd1;
          event_sum   <= event_sum + {18'b0, beat_evt};
          if (!idx_seen) begin
            idx_low  <= beat_idx;
            idx_high <= beat_idx;
            idx_seen <= 1'b1;
          end else if (idx_advance) begin
            idx_high <= beat_idx;
          end
        end else begin
          other_count <= other_count + 32'd1;
        end
        if (beat_last) begin
          if (beat_type != scam_pkg::TYPE_CYCLE) begin
            bad_last_count <= bad_last_count + 32'd1;
          end
          if (cwp_new > 14'd1) begin
            multi_count <= multi_count + 32'd1;
          end
          bip <= 14'd0;
          cwp <= 14'd0;
        end else begin
          bip <= bip_inc;
          cwp <= cwp_new;
        end
      end
      if (pkt_end || is_empty) begin
        if (polls_ext < poll_min) begin
          poll_min <= polls_ext;
        end
        if (polls_ext > poll_max) begin
          poll_max <= polls_ext;
        end
      end
    end
  end

  scam_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk       (clk),
    .wr_en     (s1_upd),
    .wr_addr   (s1_upd_addr),
    .wr_data   (wr_data),
    .rd_a_addr (hist_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (AW'(stat_select - scam_pkg::SEL_ZERO_COUNT)),
    .rd_b_data (rd_b_data)
  );

  assign upd_base = (fw_valid && (fw_addr == s1_upd_addr)) ? fw_data :
                    (hist_valid[s1_upd_addr] ? rd_a_data : 32'd0);
  assign wr_data  = upd_base + 32'd1;

  assign hist_value = (fw_valid && (fw_addr == s1_rd_addr)) ? fw_data :
                      (hist_valid[s1_rd_addr] ? rd_b_data : 32'd0);
  assign s1_result  = s1_rd_hist ? hist_value : s1_scalar;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_upd     <= 1'b0;
      s1_rd      <= 1'b0;
      fw_valid   <= 1'b0;
      hist_valid <= '0;
    end else begin
      s1_upd   <= pkt_end || is_empty;
      s1_rd    <= is_read;
      fw_valid <= s1_upd;
      if (s1_upd) begin
        hist_valid[s1_upd_addr] <= 1'b1;
      end
    end
    s1_upd_addr <= hist_addr;
    s1_rd_hist  <= sel_hist;
    s1_rd_addr  <= AW'(stat_select - scam_pkg::SEL_ZERO_COUNT);
    s1_scalar   <= scalar_value;
    fw_addr     <= s1_upd_addr;
    fw_data     <= wr_data;
  end

  assign out_valid  = (count != 2'd0);
  assign pop        = out_valid && !out_stall;
  assign read_value = fifo_mem[rd_ptr];
  assign in_stall   = ({1'b0, count} + {2'b0, s1_rd}) >= 3'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 2'd0;
    end else begin
      if (s1_rd) begin
        wr_ptr <= (wr_ptr == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr + 2'd1;
      end
      if (s1_rd && !pop) begin
        count <= count + 2'd1;
      end else if (!s1_rd && pop) begin
        count <= count - 2'd1;
      end
    end
    if (s1_rd) begin
      fifo_mem[wr_ptr] <= s1_result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/scam_checker.sv
// ----------------------------------------------------------------------------
// Stream accounting monitor checker
// Port-level properties of the monitor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stream_contract_accounting_monitor_unit_defines.svh"

module scam_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  req_type,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] read_value
);

  logic read_taken;

  assign read_taken = in_valid && !in_stall && (req_type == scam_pkg::REQ_READ);

  `SCAM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")
  `SCAM_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(read_value), "stalled result changed")
  `SCAM_ASSERT_RESET(a_reset_empty, clk, rst, !out_valid, "result offered after reset")
  `SCAM_ASSERT_NOW(a_read_result, clk, rst, read_taken, ##2 out_valid, "read transaction gave no result")
  `SCAM_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid, "input stalled with no result waiting")

endmodule

bind stream_contract_accounting_monitor_unit scam_checker u_scam_checker (.*);

`default_nettype wire

>>> tb/sv/tb_stream_contract_accounting_monitor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stream accounting monitor testbench
// Feeds packets of typed beats, empty-packet notices and counter reads into
// the monitor under random idling on both sides. It keeps its own copy of
// every counter and checks each read result in order against that copy.
// ----------------------------------------------------------------------------

module tb_stream_contract_accounting_monitor_unit;
  import scam_pkg::*;

  localparam int PKT_BEAT_LIMIT  = 8191;
  localparam int LEN_BINS        = 14;
  localparam int QUIET_TAIL      = 300;
  localparam int HOLD_AT         = 50;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 8;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam logic [4:0] SEL_OVER_COUNT = 5'd12;
  localparam logic [4:0] SEL_HIST_BASE  = 5'd13;
  localparam logic [4:0] SEL_UNUSED     = 5'd31;

  typedef struct {
    logic [1:0]  kind;
    logic [63:0] data;
    logic        is_last;
    logic [24:0] polls;
    logic [4:0]  sel;
  } request_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  req_type    = REQ_BEAT;
  logic [63:0] beat_data   = '0;
  logic        beat_last   = 1'b0;
  logic [24:0] wait_polls  = '0;
  logic [4:0]  stat_select = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [31:0] read_value;

  request_t    request_q[$];
  logic [31:0] read_values_due[$];

  int          planned       = 0;
  int          real_items    = 0;
  int          items_taken   = 0;
  int          reads_checked = 0;
  int          packets_seen  = 0;
  int          failures      = 0;
  int          idle_run      = 0;
  int          send_gap      = 0;
  int          recv_gap      = 0;
  int          hold_left     = 0;
  logic        hold_done     = 1'b0;
  logic        quiet         = 1'b0;
  logic [23:0] index_walk    = '0;

  // Expected state of the monitor.
  logic [31:0] peaks, cycle_words, event_total, others, bad_tail, multi_cycle;
  logic [23:0] idx_first, idx_top;
  logic        idx_valid;
  logic [31:0] polls_lo, polls_hi, empty_pkts, long_pkts;
  logic [13:0] pkt_beats, pkt_cycles;
  logic [31:0] len_bins[LEN_BINS];

  stream_contract_accounting_monitor_unit #(
    .MAX_PACKET_BEATS(PKT_BEAT_LIMIT),
    .HIST_BUCKETS(LEN_BINS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .beat_data(beat_data),
    .beat_last(beat_last),
    .wait_polls(wait_polls),
    .stat_select(stat_select),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(read_value)
  );

  always #10 clk = ~clk;

  function automatic void clear_counters();
    peaks       = '0;
    cycle_words = '0;
    event_total = '0;
    others      = '0;
    bad_tail    = '0;
    multi_cycle = '0;
    idx_first   = '0;
    idx_top     = '0;
    idx_valid   = 1'b0;
    polls_lo    = '1;
    polls_hi    = '0;
    empty_pkts  = '0;
    long_pkts   = '0;
    pkt_beats   = '0;
    pkt_cycles  = '0;
    foreach (len_bins[k]) len_bins[k] = '0;
  endfunction

  function automatic void note_polls(input logic [24:0] polls);
    if (32'(polls) < polls_lo) polls_lo = 32'(polls);
    if (32'(polls) > polls_hi) polls_hi = 32'(polls);
  endfunction

  function automatic void file_length(input int beats);
    int bound;
    bit placed;
    placed = 1'b0;
    if (beats == 0) begin
      empty_pkts++;
    end else begin
      for (int k = 0; k < LEN_BINS && !placed; k++) begin
        bound = (k < LEN_BINS - 1) ? (1 << k) : PKT_BEAT_LIMIT;
        if (beats <= bound) begin
          len_bins[k]++;
          placed = 1'b1;
        end
      end
      if (!placed) long_pkts++;
    end
  endfunction

  function automatic logic [31:0] read_counter(input logic [4:0] sel);
    int slot;
    slot = int'(sel) - int'(SEL_HIST_BASE);
    case (sel)
      SEL_PEAK:       return peaks;
      SEL_CYCLE:      return cycle_words;
      SEL_EVENT_SUM:  return event_total;
      SEL_OTHER:      return others;
      SEL_BAD_LAST:   return bad_tail;
      SEL_MULTI:      return multi_cycle;
      SEL_IDX_LOW:    return {8'd0, idx_first};
      SEL_IDX_HIGH:   return {8'd0, idx_top};
      SEL_IDX_SEEN:   return {31'd0, idx_valid};
      SEL_POLL_MIN:   return polls_lo;
      SEL_POLL_MAX:   return polls_hi;
      SEL_ZERO_COUNT: return empty_pkts;
      SEL_OVER_COUNT: return long_pkts;
      default: ;
    endcase
    if (slot >= 0 && slot < LEN_BINS) return len_bins[slot];
    return '0;
  endfunction

  function automatic void track_request(input request_t r);
    logic [7:0]  kind_byte;
    logic [23:0] idx;
    kind_byte = r.data[63:56];
    idx       = r.data[55:32];
    case (r.kind)
      REQ_BEAT: begin
        if (pkt_beats != CNT14_MAX) pkt_beats++;
        if (kind_byte == TYPE_PEAK) begin
          peaks++;
        end else if (kind_byte == TYPE_CYCLE) begin
          cycle_words++;
          event_total += 32'(r.data[29:16]);
          if (!idx_valid) begin
            idx_first = idx;
            idx_top   = idx;
            idx_valid = 1'b1;
          end else if (idx > idx_top && (idx - idx_top) < HALF_RANGE) begin
            idx_top = idx;
          end
          if (pkt_cycles != CNT14_MAX) pkt_cycles++;
        end else begin
          others++;
        end
        if (r.is_last) begin
          if (kind_byte != TYPE_CYCLE) bad_tail++;
          if (pkt_cycles > 14'd1) multi_cycle++;
          note_polls(r.polls);
          file_length(int'(pkt_beats));
          pkt_beats  = '0;
          pkt_cycles = '0;
          packets_seen++;
        end
      end
      REQ_READ: begin
        read_values_due.push_back(read_counter(r.sel));
      end
      REQ_EMPTY: begin
        note_polls(r.polls);
        file_length(0);
        packets_seen++;
      end
      default: ;
    endcase
  endfunction

  // Stimulus helpers.
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [4:0] rand_sel();
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [24:0] rand_polls();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return 25'($urandom);
  endfunction

  function automatic logic [23:0] next_cycle_index();
    case ($urandom_range(0, 9))
      0: index_walk = 24'($urandom);
      1: index_walk = index_walk - 24'($urandom_range(1, 4000));
      2: index_walk = index_walk + HALF_RANGE + 24'($urandom_range(0, 64));
      3: index_walk = index_walk + HALF_RANGE - 24'd1;
      default: index_walk = index_walk + 24'($urandom_range(1, 64));
    endcase
    return index_walk;
  endfunction

  function automatic logic [63:0] make_word(input logic [7:0] kind_byte);
    logic [63:0] w;
    w = rand64();
    w[63:56] = kind_byte;
    if (kind_byte == TYPE_CYCLE) begin
      w[55:32] = next_cycle_index();
      if ($urandom_range(0, 9) == 0) w[29:16] = CNT14_MAX;
    end
    return w;
  endfunction

  function automatic logic [7:0] filler_type();
    logic [7:0] t;
    t = 8'($urandom_range(2, 255));
    return ($urandom_range(0, 2) != 0) ? TYPE_PEAK : t;
  endfunction

  function automatic logic [7:0] any_type(input int cycle_pct);
    if ($urandom_range(0, 99) < cycle_pct) return TYPE_CYCLE;
    return filler_type();
  endfunction

  function automatic int random_length();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick < 24) return $urandom_range(1, 4);
    if (pick < 34) return $urandom_range(5, 17);
    if (pick < 39) return $urandom_range(18, 70);
    return $urandom_range(100, 300);
  endfunction

  task automatic queue_request(input logic [1:0] kind, input logic [63:0] data,
                               input logic is_last, input logic [24:0] polls,
                               input logic [4:0] sel);
    request_t r;
    r.kind    = kind;
    r.data    = data;
    r.is_last = is_last;
    r.polls   = polls;
    r.sel     = sel;
    request_q.push_back(r);
    planned++;
    if (kind != REQ_UNUSED) real_items++;
  endtask

  task automatic queue_read(input logic [4:0] sel);
    queue_request(REQ_READ, rand64(), 1'($urandom_range(0, 1)), rand_polls(), sel);
  endtask

  task automatic queue_packet(input int len, input bit tidy, input int cycle_pct);
    logic [7:0] t;
    for (int b = 0; b < len; b++) begin
      if (tidy && b == len - 1) t = TYPE_CYCLE;
      else if (tidy) t = filler_type();
      else t = any_type(cycle_pct);
      queue_request(REQ_BEAT, make_word(t), b == len - 1, rand_polls(), rand_sel());
      if (b != len - 1 && $urandom_range(0, 15) == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_request(REQ_EMPTY, rand64(), 1'($urandom_range(0, 1)), rand_polls(),
                        rand_sel());
        end else begin
          queue_read(rand_sel());
        end
      end
    end
  endtask

  task automatic random_burst(input int n);
    int first;
    int pick;
    first = real_items;
    while (real_items - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_packet(random_length(), $urandom_range(0, 3) != 0, $urandom_range(0, 100));
      end else if (pick < 90) begin
        queue_read(rand_sel());
      end else if (pick < 97) begin
        queue_request(REQ_EMPTY, rand64(), 1'($urandom_range(0, 1)), rand_polls(),
                      rand_sel());
      end else begin
        queue_request(REQ_UNUSED, rand64(), 1'($urandom_range(0, 1)), rand_polls(),
                      rand_sel());
      end
    end
  endtask

  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      quiet    <= 1'b0;
    end else begin
      quiet <= (request_q.size() <= QUIET_TAIL);
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          nxt = request_q.pop_front();
          in_valid    <= 1'b1;
          req_type    <= nxt.kind;
          beat_data   <= nxt.data;
          beat_last   <= nxt.is_last;
          wait_polls  <= nxt.polls;
          stat_select <= nxt.sel;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap  <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap  <= $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_reads
    request_t    got;
    logic [31:0] want;
    if (rst) begin
      items_taken <= 0;
      idle_run    <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        got.kind    = req_type;
        got.data    = beat_data;
        got.is_last = beat_last;
        got.polls   = wait_polls;
        got.sel     = stat_select;
        track_request(got);
        items_taken <= items_taken + 1;
      end
      if (out_valid && !out_stall) begin
        if (read_values_due.size() == 0) begin
          $error("read_value arrived with no read outstanding: actual %0h", read_value);
          failures++;
        end else begin
          want = read_values_due.pop_front();
          reads_checked++;
          if (read_value !== want) begin
            $error("read_value mismatch: expected %0h, actual %0h", want, read_value);
            failures++;
          end
        end
      end
      idle_run <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ? 0 : idle_run + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", idle_run);
      $display("tb_stream_contract_accounting_monitor_unit failed");
      $finish;
    end
  end

  initial begin
    clear_counters();

    // Counters straight out of reset.
    queue_read(SEL_POLL_MIN);
    queue_read(SEL_IDX_SEEN);
    queue_read(SEL_IDX_HIGH);
    // A packet whose only beat is a peak word, with the smallest wait count.
    queue_request(REQ_BEAT, {TYPE_PEAK, 56'd0}, 1'b1, 25'd0, 5'd0);
    // Largest cycle index and event count, then reads in the middle of the packet.
    queue_request(REQ_BEAT, {TYPE_CYCLE, 24'hffffff, 2'b11, CNT14_MAX, 16'hffff}, 1'b0,
                  25'h1ffffff, 5'h1f);
    queue_read(SEL_CYCLE);
    queue_read(SEL_EVENT_SUM);
    // An empty packet while a packet is open, with the largest wait count.
    queue_request(REQ_EMPTY, rand64(), 1'b1, 25'h1ffffff, rand_sel());
    // Another word of type cycle closes the packet; its index lies below the top.
    queue_request(REQ_BEAT, {TYPE_CYCLE, 56'd0}, 1'b1, rand_polls(), rand_sel());
    queue_read(SEL_MULTI);
    queue_read(SEL_IDX_LOW);
    queue_read(SEL_IDX_HIGH);
    queue_request(REQ_BEAT, {8'hff, 56'hffffffffffffff}, 1'b0, rand_polls(), rand_sel());
    queue_request(REQ_BEAT, {TYPE_CYCLE, 24'h7fffff, 32'd0}, 1'b1, rand_polls(), rand_sel());
    queue_request(REQ_UNUSED, rand64(), 1'b1, rand_polls(), SEL_POLL_MIN);
    queue_read(SEL_UNUSED);
    queue_read(SEL_POLL_MIN);
    queue_read(SEL_POLL_MAX);
    queue_read(SEL_ZERO_COUNT);
    queue_read(SEL_BAD_LAST);
    queue_read(SEL_OTHER);
    queue_read(SEL_PEAK);
    queue_read(SEL_HIST_BASE);
    queue_read(SEL_HIST_BASE + 5'd1);

    random_burst(330);
    // A long packet reaches one of the upper buckets.
    queue_packet(513, 1'b1, 0);
    random_burst(350);
    for (int s = 0; s < 32; s++) queue_read(5'(s));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != planned || read_values_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d transactions in %0d packets and checked %0d read results,",
             items_taken, packets_seen, reads_checked);
    $display("including a %0d-cycle output hold and a packet of 513 beats.",
             HOLD_CYCLES);
    if (failures == 0) begin
      $display("tb_stream_contract_accounting_monitor_unit passed");
    end else begin
      $display("tb_stream_contract_accounting_monitor_unit failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/scam_pkg.sv
rtl/scam_ram.sv
rtl/stream_contract_accounting_monitor_unit.sv
rtl/scam_checker.sv
tb/sv/tb_stream_contract_accounting_monitor_unit.sv
